// File: sv/lapt_pkg.sv
`timescale 1ns / 1ps
// lapt_pkg: shared widths, op codes and control types of the lookahead pair trainer
package lapt_pkg;

    localparam int OP_W   = 2;
    localparam int CALL_W = 9;
    localparam int DIST_W = 4;
    localparam int FILL_W = 4;
    localparam int WLEN_W = 5;

    localparam logic [OP_W-1:0] OP_PRELOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_TRACE   = 2'd1;
    localparam logic [OP_W-1:0] OP_READ    = 2'd2;

    localparam logic [WLEN_W-1:0] WLEN_RESET = 5'd6;

    typedef enum logic {
        TBL_SET,
        TBL_READ
    } tbl_op_t;

    typedef struct packed {
        logic    valid;
        tbl_op_t op;
    } tbl_req_t;

    typedef struct packed {
        logic busy;
        logic rd_valid;
        logic rd_bit;
    } tbl_stat_t;

    typedef struct packed {
        logic push;
        logic shift;
        logic load_fill;
    } win_cmd_t;

    typedef struct packed {
        logic              pair_seen;
        logic [FILL_W-1:0] window_fill;
    } rsp_item_t;

endpackage

// File: sv/lapt_if.sv
`timescale 1ns / 1ps
// lapt_if: request and response channel interfaces
interface lapt_req_if;
    logic                      valid;
    logic                      ready;
    logic [lapt_pkg::OP_W-1:0]   op;
    logic [lapt_pkg::CALL_W-1:0] call_number;
    logic [lapt_pkg::CALL_W-1:0] earlier_call;
    logic [lapt_pkg::DIST_W-1:0] pair_distance;

    modport source (output valid, output op, output call_number, output earlier_call,
                    output pair_distance, input ready);
    modport sink (input valid, input op, input call_number, input earlier_call,
                  input pair_distance, output ready);
endinterface

interface lapt_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        pair_seen;
    logic [lapt_pkg::FILL_W-1:0] window_fill;

    modport source (output valid, output pair_seen, output window_fill, input ready);
    modport sink (input valid, input pair_seen, input window_fill, output ready);
endinterface

// File: sv/lapt_table.sv
`timescale 1ns / 1ps
// lapt_table: pair bit memory with read-modify-write, forwarding and clearing pass
module lapt_table #(
    parameter int NUM_CALLS  = 512,
    parameter int MAX_WINDOW = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  lapt_pkg::tbl_req_t                     req,
    input  logic [$clog2(NUM_CALLS*NUM_CALLS)-1:0] addr,
    input  logic [$clog2(MAX_WINDOW)-1:0]          pair_dist,
    output lapt_pkg::tbl_stat_t                    stat
);
    import lapt_pkg::*;

    localparam int DEPTH = NUM_CALLS * NUM_CALLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = $clog2(MAX_WINDOW);

    logic [MAX_WINDOW-1:0] mem [DEPTH];

    logic [MAX_WINDOW-1:0] rdata_reg;
    logic                  p_valid_reg;
    tbl_op_t               p_op_reg;
    logic [AW-1:0]         p_addr_reg;
    logic [FW-1:0]         p_dist_reg;

    logic                  wr_valid_reg;
    logic [AW-1:0]         wr_addr_reg;
    logic [MAX_WINDOW-1:0] wr_data_reg;

    logic                  busy_reg;
    logic [AW-1:0]         clr_addr_reg;

    logic [MAX_WINDOW-1:0] merged;
    logic [MAX_WINDOW-1:0] set_word;
    logic                  wr_en;

    // word written in the same cycle as the read returns stale data
    assign merged   = (wr_valid_reg && (wr_addr_reg == p_addr_reg)) ? wr_data_reg : rdata_reg;
    assign set_word = merged | (MAX_WINDOW'(1) << p_dist_reg);
    assign wr_en    = p_valid_reg && (p_op_reg == TBL_SET);

    assign stat.busy     = busy_reg;
    assign stat.rd_valid = p_valid_reg && (p_op_reg == TBL_READ);
    assign stat.rd_bit   = merged[p_dist_reg];

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[p_addr_reg] <= set_word;
        end
        if (req.valid)
        begin
            rdata_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        p_op_reg    <= req.op;
        p_addr_reg  <= addr;
        p_dist_reg  <= pair_dist;
        wr_addr_reg <= p_addr_reg;
        wr_data_reg <= set_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg  <= 1'b0;
            wr_valid_reg <= 1'b0;
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            p_valid_reg  <= req.valid;
            wr_valid_reg <= wr_en;
            if (busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

// File: sv/lapt_window.sv
`timescale 1ns / 1ps
// lapt_window: sliding call window with fill count
module lapt_window #(
    parameter int MAX_WINDOW = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lapt_pkg::win_cmd_t            cmd,
    input  logic [lapt_pkg::CALL_W-1:0]   push_data,
    input  logic [$clog2(MAX_WINDOW)-1:0] fill_val,
    input  logic [$clog2(MAX_WINDOW)-1:0] rd_idx,
    output logic [lapt_pkg::CALL_W-1:0]   rd_data,
    output logic [$clog2(MAX_WINDOW)-1:0] fill
);
    import lapt_pkg::*;

    localparam int FW = $clog2(MAX_WINDOW);

    logic [CALL_W-1:0] win_reg [MAX_WINDOW];
    logic [FW-1:0]     fill_reg;

    assign rd_data = win_reg[rd_idx];
    assign fill    = fill_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            win_reg[fill_reg] <= push_data;
        end
        else if (cmd.shift)
        begin
            for (int i = 0; i < MAX_WINDOW - 1; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (cmd.load_fill)
        begin
            fill_reg <= fill_val;
        end
    end

endmodule

// File: sv/lookahead_pair_profile_trainer.sv
`timescale 1ns / 1ps
// lookahead_pair_profile_trainer: top level with sequencer, config register and response queue
// After reset the pair table is cleared one word per cycle, all NUM_CALLS*NUM_CALLS words
// (262144 at the default), with req.ready low; configuration writes are taken meanwhile.
// Then a preload, an unused op, an out-of-range read, or a trace call while the window is
// still filling pushes its response when accepted; an in-range read waits in S_RDWAIT.
// A trace call that completes the window shifts out the extra surplus calls left from a
// shrunk window (S_ALIGN), then does len - 1 pair updates, where len is the clamped window
// length (S_PAIR), then shifts and responds (S_SHIFT): every pair is one read-modify-write
// of a table word, one pair per cycle. Results go into a two-entry queue, so requests keep
// flowing while a response is stalled, until the queue is full.
module lookahead_pair_profile_trainer #(
    parameter int NUM_CALLS  = 512,
    parameter int MAX_WINDOW = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [lapt_pkg::WLEN_W-1:0] cfg_wdata,
    lapt_req_if.sink                    req,
    lapt_rsp_if.source                  rsp
);
    import lapt_pkg::*;

    localparam int AW  = $clog2(NUM_CALLS * NUM_CALLS);
    localparam int FW  = $clog2(MAX_WINDOW);
    localparam int LW  = $clog2(MAX_WINDOW + 1);
    localparam int DSW = (FW > DIST_W) ? FW : DIST_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RDWAIT = 3'd1;
    localparam logic [2:0] S_ALIGN  = 3'd2;
    localparam logic [2:0] S_PAIR   = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;

    logic [WLEN_W-1:0] window_length_reg;
    logic [2:0]        state_reg, state_next;
    logic [FW-1:0]     i_reg, i_next;
    logic [LW-1:0]     off_reg, off_next;
    logic [CALL_W-1:0] newest_reg, newest_next;

    rsp_item_t         ofifo_reg [2];
    logic              wptr_reg, rptr_reg;
    logic [1:0]        ocnt_reg;

    logic [LW-1:0]     len;
    logic [LW-1:0]     n;
    logic [LW-1:0]     off;
    logic [LW-1:0]     dist_pair;
    logic [CALL_W-1:0] cur_sel, early_sel;
    logic [DSW-1:0]    dist_sel;
    logic              pair_ok;
    logic [AW-1:0]     tbl_addr;
    logic              req_acc, rsp_pop;
    logic              push_rsp;
    rsp_item_t         rsp_item;
    logic [FILL_W-1:0] fill_out;

    tbl_req_t          tcmd;
    tbl_stat_t         tstat;
    win_cmd_t          wcmd;
    logic [FW-1:0]     wfill_val;
    logic [CALL_W-1:0] win_rd;
    logic [FW-1:0]     win_fill;

    lapt_table #(
        .NUM_CALLS  (NUM_CALLS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (tcmd),
        .addr     (tbl_addr),
        .pair_dist(FW'(dist_sel)),
        .stat     (tstat)
    );

    lapt_window #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (wcmd),
        .push_data(req.call_number),
        .fill_val (wfill_val),
        .rd_idx   (i_reg),
        .rd_data  (win_rd),
        .fill     (win_fill)
    );

    // clamped window length
    always_comb
    begin
        if (window_length_reg < WLEN_W'(2))
        begin
            len = LW'(2);
        end
        else if (32'(window_length_reg) > MAX_WINDOW)
        begin
            len = LW'(MAX_WINDOW);
        end
        else
        begin
            len = LW'(window_length_reg);
        end
    end

    assign n         = LW'(win_fill) + LW'(1);
    assign off       = n - len;
    assign dist_pair = len - LW'(1) - LW'(i_reg);
    assign fill_out  = FILL_W'(win_fill);

    assign pair_ok  = (32'(cur_sel) < NUM_CALLS) && (32'(early_sel) < NUM_CALLS)
                      && (32'(dist_sel) < MAX_WINDOW);
    assign tbl_addr = AW'(32'(cur_sel) * 32'(NUM_CALLS) + 32'(early_sel));

    assign req.ready = (state_reg == S_IDLE) && !tstat.busy && (ocnt_reg != 2'd2);
    assign req_acc   = req.valid && req.ready;

    assign rsp.valid       = (ocnt_reg != 2'd0);
    assign rsp.pair_seen   = ofifo_reg[rptr_reg].pair_seen;
    assign rsp.window_fill = ofifo_reg[rptr_reg].window_fill;
    assign rsp_pop         = rsp.valid && rsp.ready;

    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        off_next    = off_reg;
        newest_next = newest_reg;
        tcmd        = '0;
        wcmd        = '0;
        wfill_val   = '0;
        push_rsp    = 1'b0;
        rsp_item    = '0;
        cur_sel     = req.call_number;
        early_sel   = req.earlier_call;
        dist_sel    = DSW'(req.pair_distance);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    unique case (req.op)
                        OP_PRELOAD:
                        begin
                            tcmd.valid = pair_ok;
                            tcmd.op    = TBL_SET;
                            push_rsp   = 1'b1;
                            rsp_item   = '{pair_seen: 1'b0, window_fill: fill_out};
                        end
                        OP_TRACE:
                        begin
                            wcmd.push = 1'b1;
                            if (n < len)
                            begin
                                wcmd.load_fill = 1'b1;
                                wfill_val      = FW'(n);
                                push_rsp       = 1'b1;
                                rsp_item = '{pair_seen: 1'b0, window_fill: FILL_W'(n)};
                            end
                            else
                            begin
                                newest_next = req.call_number;
                                i_next      = '0;
                                off_next    = off;
                                state_next  = (off != '0) ? S_ALIGN : S_PAIR;
                            end
                        end
                        OP_READ:
                        begin
                            if (pair_ok)
                            begin
                                tcmd.valid = 1'b1;
                                tcmd.op    = TBL_READ;
                                state_next = S_RDWAIT;
                            end
                            else
                            begin
                                push_rsp = 1'b1;
                                rsp_item = '{pair_seen: 1'b0, window_fill: fill_out};
                            end
                        end
                        default:
                        begin
                            push_rsp = 1'b1;
                            rsp_item = '{pair_seen: 1'b0, window_fill: fill_out};
                        end
                    endcase
                end
            end
            S_RDWAIT:
            begin
                push_rsp   = 1'b1;
                rsp_item   = '{pair_seen: tstat.rd_bit, window_fill: fill_out};
                state_next = S_IDLE;
            end
            S_ALIGN:
            begin
                // drop surplus oldest calls
                wcmd.shift = 1'b1;
                off_next   = off_reg - LW'(1);
                if (off_reg == LW'(1))
                begin
                    state_next = S_PAIR;
                end
            end
            S_PAIR:
            begin
                cur_sel    = newest_reg;
                early_sel  = win_rd;
                dist_sel   = DSW'(dist_pair);
                tcmd.valid = pair_ok;
                tcmd.op    = TBL_SET;
                if (i_reg == FW'(len - LW'(2)))
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    i_next = i_reg + FW'(1);
                end
            end
            S_SHIFT:
            begin
                wcmd.shift     = 1'b1;
                wcmd.load_fill = 1'b1;
                wfill_val      = FW'(len - LW'(1));
                push_rsp       = 1'b1;
                rsp_item = '{pair_seen: 1'b0, window_fill: FILL_W'(len - LW'(1))};
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        off_reg    <= off_next;
        newest_reg <= newest_next;
        if (push_rsp)
        begin
            ofifo_reg[wptr_reg] <= rsp_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WLEN_RESET;
            state_reg         <= S_IDLE;
            wptr_reg          <= 1'b0;
            rptr_reg          <= 1'b0;
            ocnt_reg          <= 2'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_length_reg <= cfg_wdata;
            end
            state_reg <= state_next;
            if (push_rsp)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (rsp_pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            ocnt_reg <= ocnt_reg + 2'(push_rsp) - 2'(rsp_pop);
        end
    end

endmodule

// File: sv/lapt_checker.sv
`timescale 1ns / 1ps
// lapt_checker: port-level assertions for the trainer and their bind
module lapt_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic                        rsp_pair_seen,
    input logic [lapt_pkg::FILL_W-1:0] rsp_window_fill
);
    import lapt_pkg::*;

    logic [2:0]        outst_reg;
    logic [FILL_W-1:0] last_fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outst_reg     <= '0;
            last_fill_reg <= '0;
        end
        else
        begin
            outst_reg <= outst_reg + 3'(req_valid && req_ready) - 3'(rsp_valid && rsp_ready);
            if (rsp_valid && rsp_ready)
            begin
                last_fill_reg <= rsp_window_fill;
            end
        end
    end

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pair_seen)
                                    && $stable(rsp_window_fill))
        else $error("response changed while stalled");

    // no response without an outstanding request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> outst_reg != 3'd0)
        else $error("response without request");

    // at most two requests in flight
    a_outst_bound: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> outst_reg < 3'd2)
        else $error("too many requests in flight");

    // a read hit leaves the window fill as the last response showed it
    a_read_fill: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_pair_seen |-> rsp_window_fill == last_fill_reg)
        else $error("read changed window fill");

endmodule

bind lookahead_pair_profile_trainer lapt_checker u_lapt_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_pair_seen  (rsp.pair_seen),
    .rsp_window_fill(rsp.window_fill)
);

// File: tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for the lookahead pair profile trainer, predictor-based
module tb;
    import lapt_pkg::*;

    localparam int NCALL        = 512;
    localparam int MAXWIN       = 16;
    localparam int STALL_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 40;
    localparam int PHASE_ITEMS  = 240;
    localparam int NPHASE       = 8;
    localparam int NDIR         = 25;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CALL_W-1:0] call;
        logic [CALL_W-1:0] early;
        logic [DIST_W-1:0] pair_dist;
        logic              typed;
        logic              seen;
        logic [FILL_W-1:0] fill;
    } stim_row_t;

    // typed rows carry the expected result in the last two fields
    stim_row_t directed_rows [0:NDIR-1] = '{
        '{OP_READ,    9'd0,   9'd0,   4'd0,  1'b1, 1'b0, 4'd0},
        '{OP_READ,    9'd511, 9'd511, 4'd15, 1'b1, 1'b0, 4'd0},
        '{OP_PRELOAD, 9'd511, 9'd511, 4'd15, 1'b1, 1'b0, 4'd0},
        '{OP_READ,    9'd511, 9'd511, 4'd15, 1'b1, 1'b1, 4'd0},
        '{OP_PRELOAD, 9'd0,   9'd0,   4'd0,  1'b1, 1'b0, 4'd0},
        '{OP_READ,    9'd0,   9'd0,   4'd0,  1'b1, 1'b1, 4'd0},
        '{OP_UNUSED,  9'd511, 9'd511, 4'd15, 1'b1, 1'b0, 4'd0},
        '{OP_READ,    9'd511, 9'd511, 4'd14, 1'b1, 1'b0, 4'd0},
        '{OP_READ,    9'd511, 9'd0,   4'd15, 1'b0, 1'b0, 4'd0},
        '{OP_TRACE,   9'd10,  9'd0,   4'd0,  1'b1, 1'b0, 4'd1},
        '{OP_TRACE,   9'd20,  9'd511, 4'd15, 1'b1, 1'b0, 4'd2},
        '{OP_TRACE,   9'd30,  9'd0,   4'd0,  1'b1, 1'b0, 4'd3},
        '{OP_TRACE,   9'd40,  9'd0,   4'd0,  1'b1, 1'b0, 4'd4},
        '{OP_TRACE,   9'd50,  9'd0,   4'd0,  1'b1, 1'b0, 4'd5},
        '{OP_TRACE,   9'd60,  9'd0,   4'd0,  1'b1, 1'b0, 4'd5},
        '{OP_READ,    9'd60,  9'd10,  4'd5,  1'b1, 1'b1, 4'd5},
        '{OP_READ,    9'd60,  9'd50,  4'd1,  1'b1, 1'b1, 4'd5},
        '{OP_READ,    9'd60,  9'd10,  4'd4,  1'b1, 1'b0, 4'd5},
        '{OP_TRACE,   9'd511, 9'd0,   4'd0,  1'b1, 1'b0, 4'd5},
        '{OP_TRACE,   9'd0,   9'd0,   4'd0,  1'b1, 1'b0, 4'd5},
        '{OP_READ,    9'd0,   9'd511, 4'd1,  1'b1, 1'b1, 4'd5},
        '{OP_READ,    9'd511, 9'd20,  4'd4,  1'b0, 1'b0, 4'd0},
        '{OP_UNUSED,  9'd0,   9'd0,   4'd0,  1'b1, 1'b0, 4'd5},
        '{OP_PRELOAD, 9'd60,  9'd10,  4'd4,  1'b0, 1'b0, 4'd0},
        '{OP_READ,    9'd60,  9'd10,  4'd4,  1'b0, 1'b0, 4'd0}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we;
    logic [WLEN_W-1:0] cfg_wdata;

    lapt_req_if req_if ();
    lapt_rsp_if rsp_if ();

    lookahead_pair_profile_trainer #(
        .NUM_CALLS  (NCALL),
        .MAX_WINDOW (MAXWIN)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    // profile predictor state
    bit [MAXWIN-1:0]   profile_bits [0:NCALL*NCALL-1];
    bit [CALL_W-1:0]   recent_calls [0:MAXWIN-1];
    int unsigned       held_calls = 0;
    logic [WLEN_W-1:0] window_cfg = WLEN_RESET;

    rsp_item_t         expected_q [$];
    stim_row_t         offered_row;
    int unsigned       mismatches = 0;
    int unsigned       stall_cycles = 0;
    bit                idle_enable = 1'b1;
    bit                rsp_hold_req = 1'b0;
    bit                rsp_holding = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned window_span();
        if (window_cfg < 2)
            return 2;
        if (window_cfg > MAXWIN)
            return MAXWIN;
        return 32'(window_cfg);
    endfunction

    function automatic rsp_item_t predict_step(input logic [OP_W-1:0] op,
                                               input logic [CALL_W-1:0] call,
                                               input logic [CALL_W-1:0] early,
                                               input logic [DIST_W-1:0] pair_dist);
        rsp_item_t   r;
        int unsigned span;
        int unsigned n;
        int unsigned off;
        r.pair_seen = 1'b0;
        case (op)
            OP_PRELOAD:
                profile_bits[{call, early}][pair_dist] = 1'b1;
            OP_TRACE:
            begin
                span = window_span();
                if (held_calls > MAXWIN - 1)
                    held_calls = MAXWIN - 1;
                recent_calls[held_calls] = call;
                n = held_calls + 1;
                if (n < span)
                    held_calls = n;
                else
                begin
                    off = n - span;
                    for (int i = 0; i + 1 < span; i++)
                        profile_bits[{call, recent_calls[off + i]}][span - 1 - i] = 1'b1;
                    for (int i = 0; i + 1 < span; i++)
                        recent_calls[i] = recent_calls[off + 1 + i];
                    held_calls = span - 1;
                end
            end
            OP_READ:
                r.pair_seen = profile_bits[{call, early}][pair_dist];
            default:
                ;
        endcase
        r.window_fill = held_calls[FILL_W-1:0];
        return r;
    endfunction

    always @(posedge clk)
    begin : scoreboard
        rsp_item_t want;
        rsp_item_t got;
        if (cfg_we)
            window_cfg = cfg_wdata;
        if (req_if.valid && req_if.ready)
        begin
            want = predict_step(req_if.op, req_if.call_number, req_if.earlier_call,
                                req_if.pair_distance);
            if (offered_row.typed)
            begin
                want.pair_seen   = offered_row.seen;
                want.window_fill = offered_row.fill;
            end
            expected_q.insert(expected_q.size(), want);
        end
        if (rsp_if.valid && rsp_if.ready)
        begin
            got.pair_seen   = rsp_if.pair_seen;
            got.window_fill = rsp_if.window_fill;
            if (expected_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected response: pair_seen %0d window_fill %0d",
                             got.pair_seen, got.window_fill);
                mismatches++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.pair_seen !== want.pair_seen || got.window_fill !== want.window_fill)
                begin
                    if (mismatches < 10)
                        $display("mismatch at %0t: seen exp %0d got %0d, fill exp %0d got %0d",
                                 $realtime, want.pair_seen, got.pair_seen,
                                 want.window_fill, got.window_fill);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // response side: random back-pressure and one long hold
    initial
    begin
        rsp_if.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (rsp_hold_req)
            begin
                rsp_hold_req = 1'b0;
                rsp_holding  = 1'b1;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp_holding = 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 4) == 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic offer_request(input stim_row_t row);
        req_if.valid         <= 1'b1;
        req_if.op            <= row.op;
        req_if.call_number   <= row.call;
        req_if.earlier_call  <= row.early;
        req_if.pair_distance <= row.pair_dist;
        offered_row          <= row;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        if (idle_enable && !rsp_holding && $urandom_range(0, 3) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    initial
    begin
        logic [WLEN_W-1:0] phase_wlen [0:NPHASE-1];
        bit [CALL_W-1:0]   call_pool [0:7];
        stim_row_t         row;
        int unsigned       pick;
        phase_wlen = '{5'd16, 5'd2, 5'd31, 5'd0, 5'd1, 5'd17, 5'd9, 5'd0};
        phase_wlen[NPHASE-1] = WLEN_W'($urandom_range(0, 31));
        cfg_we               <= 1'b0;
        cfg_wdata            <= '0;
        req_if.valid         <= 1'b0;
        req_if.op            <= '0;
        req_if.call_number   <= '0;
        req_if.earlier_call  <= '0;
        req_if.pair_distance <= '0;
        offered_row          <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NDIR; i++)
            offer_request(directed_rows[i]);
        req_if.valid <= 1'b0;

        for (int p = 0; p < NPHASE; p++)
        begin
            while (expected_q.size() != 0)
                @(posedge clk);
            repeat (SETTLE) @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= phase_wlen[p];
            @(posedge clk);
            cfg_we <= 1'b0;
            for (int k = 0; k < 8; k++)
                call_pool[k] = CALL_W'($urandom_range(0, NCALL - 1));
            if (p == 0)
                rsp_hold_req = 1'b1;
            if (p == NPHASE - 1)
                idle_enable = 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                row  = '0;
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    row.op = OP_TRACE;
                else if (pick < 80)
                    row.op = OP_READ;
                else if (pick < 92)
                    row.op = OP_PRELOAD;
                else
                    row.op = OP_UNUSED;
                row.call  = ($urandom_range(0, 9) == 0) ? CALL_W'($urandom_range(0, NCALL - 1))
                                                        : call_pool[$urandom_range(0, 7)];
                row.early = ($urandom_range(0, 9) == 0) ? CALL_W'($urandom_range(0, NCALL - 1))
                                                        : call_pool[$urandom_range(0, 7)];
                row.pair_dist = ($urandom_range(0, 3) == 0)
                                ? DIST_W'($urandom_range(0, MAXWIN - 1))
                                : DIST_W'($urandom_range(1, window_span() - 1));
                offer_request(row);
            end
            req_if.valid <= 1'b0;
        end

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
